@@ hw/rtl/rpd_pkg.sv @@
// ----------------------------------------------------------------------------
// rpd_pkg
// Types and constants shared by the run-length payload decoder modules.
// ----------------------------------------------------------------------------
package rpd_pkg;

  localparam int CHUNK_BYTES = 16;
  localparam int LEN_W       = 10;
  localparam int CFG_IDX_W   = 2;

  localparam logic [31:0] MAX_CODED_SIZE = 32'd1048576;

  localparam logic [7:0] MODE_RAW = 8'd0;
  localparam logic [7:0] MODE_RLE = 8'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_CODEC_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH = 2'd1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_TAG      = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_OVER     = 3'd4;
  localparam logic [2:0] ST_MISMATCH = 3'd5;

  typedef struct packed {
    logic [7:0] encoded_byte;
    logic       has_byte;
    logic       last_byte;
  } enc_item_t;

  typedef struct packed {
    logic [63:0] chunk_low;
    logic [63:0] chunk_high;
    logic [4:0]  byte_count;
    logic        frame_done;
    logic [2:0]  status;
    logic        last_of_item;
  } dec_item_t;

  // One classified request from the front to the back.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [7:0]       lo;
    logic [7:0]       hi;
    logic             pair;
    logic             bad;
    logic             tag;
    logic             last;
    logic             trunc;
  } cmd_t;

endpackage

@@ hw/rtl/rpd_front.sv @@
// ----------------------------------------------------------------------------
// rpd_front
// Parses op bytes and turns each accepted item into one expansion request.
// ----------------------------------------------------------------------------
module rpd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rpd_pkg::enc_item_t item,
  input  logic [7:0]        codec_mode,
  input  logic [31:0]       expected_length,
  output rpd_pkg::cmd_t     cmd
);
  import rpd_pkg::*;

  typedef enum logic [2:0] {
    PH_OP, PH_LIT, PH_REP, PH_PLO, PH_PHI, PH_RUN
  } phase_t;

  localparam logic [1:0] TAG_LIT  = 2'd0;
  localparam logic [1:0] TAG_REP  = 2'd1;
  localparam logic [1:0] TAG_PAIR = 2'd2;

  phase_t     phase, phase_next;
  logic [5:0] op_count, op_count_next;
  logic [7:0] pair_low, pair_low_next;
  logic [7:0] pair_high, pair_high_next;
  logic       bad;
  logic [7:0] b;

  assign b   = item.encoded_byte;
  assign bad = (codec_mode > MODE_RLE) ||
               ((codec_mode == MODE_RLE) && (expected_length > MAX_CODED_SIZE));

  always_comb begin
    phase_next     = phase;
    op_count_next  = op_count;
    pair_low_next  = pair_low;
    pair_high_next = pair_high;
    cmd            = '0;
    cmd.bad        = bad;
    cmd.last       = item.last_byte;
    cmd.lo         = b;
    if (item.has_byte) begin
      if (codec_mode == MODE_RAW) begin
        cmd.len = LEN_W'(1);
      end else if (codec_mode == MODE_RLE) begin
        unique case (phase)
          PH_OP: begin
            op_count_next = b[5:0];
            if (b[7:6] == TAG_LIT) begin
              if (b[5:0] != 6'd0) phase_next = PH_LIT;
            end else if (b[7:6] == TAG_REP) begin
              phase_next = PH_REP;
            end else if (b[7:6] == TAG_PAIR) begin
              phase_next = PH_PLO;
            end else begin
              cmd.tag = 1'b1;
            end
          end
          PH_LIT: begin
            cmd.len       = LEN_W'(1);
            op_count_next = op_count - 6'd1;
            if (op_count == 6'd1) phase_next = PH_OP;
          end
          PH_REP: begin
            cmd.len    = {{(LEN_W-6){1'b0}}, op_count} + LEN_W'(3);
            phase_next = PH_OP;
          end
          PH_PLO: begin
            pair_low_next = b;
            phase_next    = PH_PHI;
          end
          PH_PHI: begin
            pair_high_next = b;
            phase_next     = PH_RUN;
          end
          PH_RUN: begin
            cmd.len    = {{(LEN_W-9){1'b0}}, b, 1'b0} + LEN_W'(4);
            cmd.lo     = pair_low;
            cmd.hi     = pair_high;
            cmd.pair   = 1'b1;
            phase_next = PH_OP;
          end
          default: phase_next = PH_OP;
        endcase
      end
    end
    if (item.last_byte) begin
      cmd.trunc     = (phase_next != PH_OP);
      phase_next    = PH_OP;
      op_count_next = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_OP;
      op_count  <= 6'd0;
      pair_low  <= 8'd0;
      pair_high <= 8'd0;
    end else if (push) begin
      phase     <= phase_next;
      op_count  <= op_count_next;
      pair_low  <= pair_low_next;
      pair_high <= pair_high_next;
    end
  end

endmodule

@@ hw/rtl/rpd_queue.sv @@
// ----------------------------------------------------------------------------
// rpd_queue
// Short request queue between the parser and the expansion engine.
// ----------------------------------------------------------------------------
module rpd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rpd_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output rpd_pkg::cmd_t head,
  output logic          head_valid,
  output logic          full
);
  import rpd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/rpd_back.sv @@
// ----------------------------------------------------------------------------
// rpd_back
// Expands requests into chunks of up to 16 bytes, tracks length and errors,
// and closes each frame with a status result.
// ----------------------------------------------------------------------------
module rpd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  rpd_pkg::cmd_t        head,
  input  logic                 head_valid,
  output logic                 pop,
  input  logic [31:0]          expected_length,
  output logic                 dec_valid,
  input  logic                 dec_stall,
  output rpd_pkg::dec_item_t   dec_item
);
  import rpd_pkg::*;

  logic [LEN_W-1:0]         done;
  logic                     st_phase;
  logic [31:0]              written;
  logic [2:0]               err;
  logic                     out_valid;
  dec_item_t                out;

  logic                     go, work, over, fin, out_free, out_load;
  logic [2:0]               err_eff, status;
  logic [LEN_W-1:0]         rem;
  logic [31:0]              room;
  logic [4:0]               take, c;
  logic [8*CHUNK_BYTES-1:0] data;

  assign out_free = !out_valid || !dec_stall;
  assign go       = head_valid && out_free;

  always_comb begin
    if (err != ST_OK)   err_eff = err;
    else if (head.bad)  err_eff = ST_BAD;
    else if (head.tag)  err_eff = ST_TAG;
    else                err_eff = ST_OK;
  end

  assign rem  = head.len - done;
  assign room = expected_length - written;
  assign take = (rem > LEN_W'(CHUNK_BYTES)) ? 5'(CHUNK_BYTES) : rem[4:0];
  assign c    = (room < {27'd0, take}) ? room[4:0] : take;
  assign work = !st_phase && (err_eff == ST_OK) && (rem != '0);
  assign over = work && (rem > {{(LEN_W-5){1'b0}}, c}) && (room == {27'd0, c});
  assign fin  = !work || (rem == {{(LEN_W-5){1'b0}}, c}) || over;

  always_comb begin
    data = '0;
    for (int k = 0; k < CHUNK_BYTES; k++) begin
      if (5'(k) < c) begin
        data[8*k +: 8] = (head.pair && (k % 2 == 1)) ? head.hi : head.lo;
      end
    end
  end

  always_comb begin
    if (err_eff != ST_OK)              status = err_eff;
    else if (head.trunc)               status = ST_TRUNC;
    else if (written != expected_length) status = ST_MISMATCH;
    else                               status = ST_OK;
  end

  assign pop      = go && fin && (work ? !head.last : 1'b1);
  assign out_load = go && (work ? (c != 5'd0) : head.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      st_phase  <= 1'b0;
      written   <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && dec_stall);
      if (go) begin
        if (work) begin
          written <= written + {27'd0, c};
          err     <= over ? ST_OVER : err_eff;
          if (fin && !head.last) begin
            done <= '0;
          end else begin
            done <= done + {{(LEN_W-5){1'b0}}, c};
          end
          if (fin && head.last) st_phase <= 1'b1;
          if (c != 5'd0) begin
            out.chunk_low    <= data[63:0];
            out.chunk_high   <= data[127:64];
            out.byte_count   <= c;
            out.frame_done   <= 1'b0;
            out.status       <= ST_OK;
            out.last_of_item <= fin && !head.last;
          end
        end else begin
          done     <= '0;
          st_phase <= 1'b0;
          if (head.last) begin
            out.chunk_low    <= '0;
            out.chunk_high   <= '0;
            out.byte_count   <= 5'd0;
            out.frame_done   <= 1'b1;
            out.status       <= status;
            out.last_of_item <= 1'b1;
            written          <= '0;
            err              <= ST_OK;
          end else begin
            err <= err_eff;
          end
        end
      end
    end
  end

  assign dec_valid = out_valid;
  assign dec_item  = out;

`ifndef SYNTHESIS
  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop with empty queue");
  a_chunk_size: assert property (@(posedge clk) disable iff (rst)
    dec_valid |-> (dec_item.byte_count <= 5'(CHUNK_BYTES)))
    else $error("chunk larger than allowed");
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    (dec_valid && !dec_item.frame_done) |->
      (dec_item.status == ST_OK && dec_item.byte_count != 5'd0))
    else $error("data chunk with status or no bytes");
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    (dec_valid && dec_item.frame_done) |->
      (dec_item.byte_count == 5'd0 && dec_item.last_of_item))
    else $error("bad status result");
  a_status_once: assert property (@(posedge clk) disable iff (rst)
    (go && st_phase) |-> pop) else $error("status request not retired");
`endif

endmodule

@@ hw/rtl/rle_payload_decoder.sv @@
// ----------------------------------------------------------------------------
// rle_payload_decoder
// Run-length payload decoder: raw or run-length coded bytes in, decoded
// chunks of up to 16 bytes out, one status result per frame.
//
//   channel | signals                                  | direction
//   enc     | enc_valid, enc_stall, enc_item           | item in
//   dec     | dec_valid, dec_stall, dec_item           | result out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// The parser takes one item per cycle while the request queue has room.
// The expansion engine emits one chunk per cycle while dec is not stalled;
// a run becomes chunks of up to 16 bytes, and frame status follows the last.
// The output register holds a result while dec is stalled; enc stalls only
// when the queue of QUEUE_DEPTH requests is full.
// Synchronous reset clears parser, queue, counters and error state.
// ----------------------------------------------------------------------------
module rle_payload_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               enc_valid,
  output logic                               enc_stall,
  input  rpd_pkg::enc_item_t                 enc_item,
  output logic                               dec_valid,
  input  logic                               dec_stall,
  output rpd_pkg::dec_item_t                 dec_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_data
);
  import rpd_pkg::*;

  logic [7:0]  codec_mode;
  logic [31:0] expected_length;
  logic        push, pop, head_valid, full;
  cmd_t        cmd, head;

  assign cfg_ready = 1'b1;
  assign enc_stall = full;
  assign push      = enc_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode      <= MODE_RAW;
      expected_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CODEC_MODE) codec_mode <= cfg_data[7:0];
      else if (cfg_index == CFG_EXPECTED_LENGTH) expected_length <= cfg_data;
    end
  end

  rpd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .item            (enc_item),
    .codec_mode      (codec_mode),
    .expected_length (expected_length),
    .cmd             (cmd)
  );

  rpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_cmd     (cmd),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  rpd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .head_valid      (head_valid),
    .pop             (pop),
    .expected_length (expected_length),
    .dec_valid       (dec_valid),
    .dec_stall       (dec_stall),
    .dec_item        (dec_item)
  );

endmodule

@@ tb/rpd_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// rpd_tb_pkg
// Op byte tags of the run-length code, shared by the stimulus and the
// checker of the payload decoder testbench.
// ----------------------------------------------------------------------------
package rpd_tb_pkg;

  typedef enum logic [1:0] {
    TAG_LITERAL  = 2'd0,
    TAG_REPEAT   = 2'd1,
    TAG_PAIR     = 2'd2,
    TAG_RESERVED = 2'd3
  } op_tag_t;

endpackage

@@ tb/rpd_decode_check.sv @@
// ----------------------------------------------------------------------------
// rpd_decode_check
// Watches the encoded, decoded and register channels of the payload decoder.
// Every accepted request is decoded here into the chunks and frame status it
// must cause; every accepted result is compared field by field against the
// oldest of those, and the number of bad results is handed back.
// ----------------------------------------------------------------------------
module rpd_decode_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          enc_valid,
  input  logic                          enc_stall,
  input  rpd_pkg::enc_item_t            enc_item,
  input  logic                          dec_valid,
  input  logic                          dec_stall,
  input  rpd_pkg::dec_item_t            dec_item,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import rpd_pkg::*;
  import rpd_tb_pkg::*;

  typedef enum logic [2:0] {
    EXPECT_OP,
    LITERALS,
    REPEAT_VALUE,
    PAIR_LOW_BYTE,
    PAIR_HIGH_BYTE,
    PAIR_RUN_LENGTH
  } parse_t;

  logic [7:0]   mode_reg;
  logic [31:0]  length_reg;
  parse_t       phase;
  logic [5:0]   op_left;
  logic [7:0]   pair_lo;
  logic [7:0]   pair_hi;
  logic [31:0]  written;
  logic [2:0]   err;
  logic [127:0] chunk_acc;
  int           fill;
  dec_item_t    held;
  bit           have_held;
  dec_item_t    due_q[$];

  function automatic void queue_result(logic [127:0] bytes, int count, logic done,
                                       logic [2:0] st);
    dec_item_t r;
    r.chunk_low    = bytes[63:0];
    r.chunk_high   = bytes[127:64];
    r.byte_count   = 5'(count);
    r.frame_done   = done;
    r.status       = st;
    r.last_of_item = 1'b0;
    if (have_held) due_q.push_back(held);
    held      = r;
    have_held = 1'b1;
  endfunction

  function automatic void flush_chunk();
    if (fill == 0) return;
    queue_result(chunk_acc, fill, 1'b0, ST_OK);
    chunk_acc = '0;
    fill      = 0;
  endfunction

  function automatic void latch_error(logic [2:0] st);
    if (err == ST_OK) err = st;
  endfunction

  function automatic void store_byte(logic [7:0] b);
    if (err != ST_OK) return;
    if (written >= length_reg) begin
      latch_error(ST_OVER);
      return;
    end
    chunk_acc[8*fill +: 8] = b;
    fill++;
    written++;
    if (fill >= CHUNK_BYTES) flush_chunk();
  endfunction

  function automatic void decode_rle_byte(logic [7:0] b);
    int i;
    int n;
    case (phase)
      EXPECT_OP: begin
        op_left = b[5:0];
        case (b[7:6])
          TAG_LITERAL: if (op_left != 0) phase = LITERALS;
          TAG_REPEAT:  phase = REPEAT_VALUE;
          TAG_PAIR:    phase = PAIR_LOW_BYTE;
          default:     latch_error(ST_TAG);
        endcase
      end
      LITERALS: begin
        store_byte(b);
        op_left = op_left - 6'd1;
        if (op_left == 0) phase = EXPECT_OP;
      end
      REPEAT_VALUE: begin
        n = int'(op_left) + 3;
        for (i = 0; i < n && err == ST_OK; i++) store_byte(b);
        phase = EXPECT_OP;
      end
      PAIR_LOW_BYTE: begin
        pair_lo = b;
        phase   = PAIR_HIGH_BYTE;
      end
      PAIR_HIGH_BYTE: begin
        pair_hi = b;
        phase   = PAIR_RUN_LENGTH;
      end
      PAIR_RUN_LENGTH: begin
        n = int'(b) + 2;
        for (i = 0; i < n && err == ST_OK; i++) begin
          store_byte(pair_lo);
          store_byte(pair_hi);
        end
        phase = EXPECT_OP;
      end
      default: phase = EXPECT_OP;
    endcase
  endfunction

  function automatic void decode_request(enc_item_t it);
    logic [2:0] st;
    chunk_acc = '0;
    fill      = 0;
    if (mode_reg > MODE_RLE || (mode_reg == MODE_RLE && length_reg > MAX_CODED_SIZE))
      latch_error(ST_BAD);
    if (it.has_byte && err == ST_OK) begin
      if (mode_reg == MODE_RAW) store_byte(it.encoded_byte);
      else decode_rle_byte(it.encoded_byte);
    end
    flush_chunk();
    if (it.last_byte) begin
      if (err != ST_OK) st = err;
      else if (phase != EXPECT_OP) st = ST_TRUNC;
      else if (written != length_reg) st = ST_MISMATCH;
      else st = ST_OK;
      queue_result('0, 0, 1'b1, st);
      phase   = EXPECT_OP;
      op_left = '0;
      written = '0;
      err     = ST_OK;
    end
    if (have_held) begin
      held.last_of_item = 1'b1;
      due_q.push_back(held);
      have_held = 1'b0;
    end
  endfunction

  function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
    if (got === want) return 1'b1;
    $display("%0t: %s expected %h, got %h", $time, name, want, got);
    return 1'b0;
  endfunction

  function automatic void check_result(dec_item_t got);
    dec_item_t want;
    bit        ok;
    if (due_q.size() == 0) begin
      $display("%0t: result with nothing expected, got %h", $time, got);
      fail_count++;
      return;
    end
    want = due_q.pop_front();
    ok   = field_ok("chunk_low", want.chunk_low, got.chunk_low);
    ok  &= field_ok("chunk_high", want.chunk_high, got.chunk_high);
    ok  &= field_ok("byte_count", 64'(want.byte_count), 64'(got.byte_count));
    ok  &= field_ok("frame_done", 64'(want.frame_done), 64'(got.frame_done));
    ok  &= field_ok("status", 64'(want.status), 64'(got.status));
    ok  &= field_ok("last_of_item", 64'(want.last_of_item), 64'(got.last_of_item));
    if (!ok) fail_count++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode_reg   = MODE_RAW;
      length_reg = '0;
      phase      = EXPECT_OP;
      op_left    = '0;
      pair_lo    = '0;
      pair_hi    = '0;
      written    = '0;
      err        = ST_OK;
      chunk_acc  = '0;
      fill       = 0;
      have_held  = 1'b0;
      fail_count = 0;
      due_q.delete();
    end else begin
      if (dec_valid && !dec_stall) check_result(dec_item);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CODEC_MODE:      mode_reg = cfg_data[7:0];
          CFG_EXPECTED_LENGTH: length_reg = cfg_data;
          default: ;
        endcase
      end
      if (enc_valid && !enc_stall) decode_request(enc_item);
    end
    pending = due_q.size();
  end

endmodule

@@ tb/tb_rle_payload_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_rle_payload_decoder
// Drives the payload decoder with directed frames covering every op, the
// field extremes and each error status, then with random raw and run-length
// frames, broken and noisy ones among them, under random gaps and stalls on
// both channels. The checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_rle_payload_decoder;
  import rpd_pkg::*;
  import rpd_tb_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam int ITEM_TARGET   = 380;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 enc_valid = 1'b0;
  logic                 enc_stall;
  enc_item_t            enc_item  = '0;
  logic                 dec_valid;
  logic                 dec_stall = 1'b0;
  dec_item_t            dec_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CODEC_MODE;
  logic [31:0]          cfg_data  = '0;
  int                   fail_count;
  int                   pending;

  int                   sent_items;
  int                   stall_cycles;
  bit                   enc_calm;
  bit                   dec_calm;
  enc_item_t            frame_q[$];
  int unsigned          frame_len;

  always #5 clk = ~clk;

  rle_payload_decoder uut (
    .clk(clk), .rst(rst),
    .enc_valid(enc_valid), .enc_stall(enc_stall), .enc_item(enc_item),
    .dec_valid(dec_valid), .dec_stall(dec_stall), .dec_item(dec_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rpd_decode_check check (
    .clk(clk), .rst(rst),
    .enc_valid(enc_valid), .enc_stall(enc_stall), .enc_item(enc_item),
    .dec_valid(dec_valid), .dec_stall(dec_stall), .dec_item(dec_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    #15_000_000;
    $display("tb_rle_payload_decoder: FAIL");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 29) == 0) dec_calm = !dec_calm;
      stall_cycles = dec_calm ? 0 : $urandom_range(0, 14);
      if (stall_cycles > 0) begin
        dec_stall <= 1'b1;
        repeat (stall_cycles) @(negedge clk);
      end
      dec_stall <= 1'b0;
      @(posedge clk);
      while (!dec_valid) @(posedge clk);
    end
  end

  task automatic send(input enc_item_t it);
    int gap;
    if ($urandom_range(0, 24) == 0) enc_calm = !enc_calm;
    gap = enc_calm ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      enc_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    enc_valid <= 1'b1;
    enc_item  <= it;
    @(posedge clk);
    while (enc_stall) @(posedge clk);
    if (it.has_byte || it.last_byte) sent_items++;
  endtask

  task automatic put(input logic [7:0] b, input logic has, input logic last);
    send({b, has, last});
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    enc_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input logic [7:0] mode, input logic [31:0] len);
    drain_and_settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CODEC_MODE;
    cfg_data  <= {24'd0, mode};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= CFG_EXPECTED_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_byte(logic [7:0] b);
    if ($urandom_range(0, 11) == 0) frame_q.push_back({8'($urandom), 1'b0, 1'b0});
    frame_q.push_back({b, 1'b1, 1'b0});
  endfunction

  function automatic void build_raw_frame();
    int n;
    int k;
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
    for (k = 0; k < n; k++) add_byte(8'($urandom));
    frame_len = n;
  endfunction

  function automatic void build_rle_frame();
    int n_ops;
    int k;
    int j;
    int cnt;
    n_ops     = $urandom_range(1, 6);
    frame_len = 0;
    for (k = 0; k < n_ops; k++) begin
      case ($urandom_range(0, 19))
        0: begin
          add_byte({TAG_RESERVED, 6'($urandom)});
          add_byte(8'($urandom));
        end
        1, 2, 3, 4, 5, 6: begin
          cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
          add_byte({TAG_LITERAL, 6'(cnt)});
          for (j = 0; j < cnt; j++) add_byte(8'($urandom));
          frame_len += cnt;
        end
        7, 8, 9, 10, 11, 12: begin
          cnt = $urandom_range(0, 63);
          add_byte({TAG_REPEAT, 6'(cnt)});
          add_byte(8'($urandom));
          frame_len += cnt + 3;
        end
        default: begin
          cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
          add_byte({TAG_PAIR, 6'($urandom)});
          add_byte(8'($urandom));
          add_byte(8'($urandom));
          add_byte(8'(cnt));
          frame_len += 2 * (cnt + 2);
        end
      endcase
    end
  endfunction

  initial begin
    enc_item_t   it;
    int          kind;
    int          k;
    int          cut;
    logic [7:0]  mode;
    logic [31:0] len;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    put(8'hFF, 1'b1, 1'b1);

    write_config(MODE_RAW, 32'd2);
    put(8'h00, 1'b1, 1'b0);
    put(8'hA5, 1'b0, 1'b0);
    put(8'hFF, 1'b1, 1'b1);

    write_config(MODE_RAW, 32'd0);
    put(8'h5A, 1'b0, 1'b1);

    write_config(MODE_RAW, 32'hFFFF_FFFF);
    put(8'h3C, 1'b1, 1'b1);

    write_config(MODE_RLE, 32'd582);
    put({TAG_LITERAL, 6'd2}, 1'b1, 1'b0);
    put(8'hAA, 1'b1, 1'b0);
    put(8'h55, 1'b1, 1'b0);
    put({TAG_LITERAL, 6'd0}, 1'b1, 1'b0);
    put({TAG_REPEAT, 6'd63}, 1'b1, 1'b0);
    put(8'h5A, 1'b1, 1'b0);
    put({TAG_PAIR, 6'd0}, 1'b1, 1'b0);
    put(8'h12, 1'b1, 1'b0);
    put(8'h34, 1'b1, 1'b0);
    put(8'hFF, 1'b1, 1'b1);
    put({TAG_RESERVED, 6'd0}, 1'b1, 1'b1);
    put({TAG_REPEAT, 6'd1}, 1'b1, 1'b1);

    write_config(MODE_RLE, 32'd3);
    put({TAG_REPEAT, 6'd1}, 1'b1, 1'b0);
    put(8'h07, 1'b1, 1'b1);

    write_config(MODE_RLE, MAX_CODED_SIZE + 32'd1);
    put({TAG_LITERAL, 6'd0}, 1'b1, 1'b1);

    write_config(8'hFF, 32'd0);
    put({TAG_LITERAL, 6'd0}, 1'b1, 1'b1);

    sent_items = 0;
    while (sent_items < ITEM_TARGET) begin
      frame_q.delete();
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        build_raw_frame();
      end else if (kind == 3) begin
        for (k = $urandom_range(1, 10); k > 0; k--) add_byte(8'($urandom));
        frame_len = $urandom_range(0, 40);
      end else begin
        build_rle_frame();
      end
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(0, frame_q.size());
        while (frame_q.size() > cut) it = frame_q.pop_back();
      end
      if (frame_q.size() > 0 && $urandom_range(0, 3) != 0) begin
        it = frame_q.pop_back();
        it.last_byte = 1'b1;
        frame_q.push_back(it);
      end else begin
        frame_q.push_back({8'($urandom), 1'b0, 1'b1});
      end

      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 15) == 0) mode = 8'($urandom_range(2, 255));
        else mode = (kind < 3) ? MODE_RAW : MODE_RLE;
        case ($urandom_range(0, 11))
          0:       len = frame_len + $urandom_range(1, 3);
          1:       len = (frame_len > 2) ? frame_len - $urandom_range(1, 2) : 32'd0;
          2:       len = $urandom;
          3:       len = MAX_CODED_SIZE + 32'($urandom_range(0, 1));
          4:       len = 32'hFFFF_FFFF;
          default: len = frame_len;
        endcase
        write_config(mode, len);
      end

      while (frame_q.size() > 0) begin
        it = frame_q.pop_front();
        send(it);
      end
    end

    drain_and_settle();
    if (fail_count == 0) begin
      $display("tb_rle_payload_decoder: PASS");
    end else begin
      $display("tb_rle_payload_decoder: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/rpd_pkg.sv
hw/rtl/rpd_front.sv
hw/rtl/rpd_queue.sv
hw/rtl/rpd_back.sv
hw/rtl/rle_payload_decoder.sv
tb/rpd_tb_pkg.sv
tb/rpd_decode_check.sv
tb/tb_rle_payload_decoder.sv
